FILE: design/odsh_pkg.sv
// Shared constants, types and register codes for the octave divider sub-harmonic mixer.
package odsh_pkg;

    localparam int STAGES          = 7;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int NUM_WEIGHTS     = 7;
    localparam int WEIGHT_WIDTH    = 16;
    localparam int THRESH_WIDTH    = 16;
    localparam int MIX_WIDTH       = 19;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [STAGES-1:0]                count_t;
    typedef logic [WEIGHT_WIDTH-1:0]          weight_t;
    typedef weight_t [NUM_WEIGHTS-1:0]        weight_arr_t;
    typedef logic [2*THRESH_WIDTH-1:0]        thresh_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]       cfg_index_t;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_THRESH   = 3'd0,
        REG_WEIGHT_0 = 3'd1,
        REG_WEIGHT_1 = 3'd2,
        REG_WEIGHT_2 = 3'd3,
        REG_WEIGHT_3 = 3'd4,
        REG_WEIGHT_4 = 3'd5,
        REG_WEIGHT_5 = 3'd6,
        REG_WEIGHT_6 = 3'd7
    } reg_index_t;

    // High threshold +0.05 in the upper half, low threshold -0.05 in the lower half
    localparam thresh_t THRESH_RESET = 32'h0666_F99A;

    // Weights 0.40 0.25 0.15 0.10 0.05 0.03 0.02, stage 0 in the lowest slot
    localparam weight_arr_t WEIGHT_RESET = {
        16'd655, 16'd983, 16'd1638, 16'd3277, 16'd4915, 16'd8192, 16'd13107
    };

    // One queued request: counter value after the update and the block marker
    typedef struct packed {
        count_t count;
        logic   last;
    } entry_t;

    // Front state seen by the top level
    typedef struct packed {
        logic   gate;
        count_t count;
    } front_stat_t;

    // Queue fill status
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_stat_t;

endpackage

FILE: design/odsh_front.sv
// Front end: accepts samples, squares them with a Schmitt trigger and steps the divider counter.
module odsh_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [odsh_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                 s_last_sample,
    input  odsh_pkg::thresh_t                    thresh,
    input  odsh_pkg::queue_stat_t                q_stat,
    output logic                                 push,
    output odsh_pkg::entry_t                     push_entry,
    output odsh_pkg::front_stat_t                f_stat
);

    logic                    gate_reg;
    logic                    gate_next;
    odsh_pkg::count_t        count_reg;
    odsh_pkg::count_t        count_next;
    logic signed [odsh_pkg::THRESH_WIDTH-1:0] hi_thr;
    logic signed [odsh_pkg::THRESH_WIDTH-1:0] lo_thr;
    logic                    accept;

    assign hi_thr  = $signed(thresh[2*odsh_pkg::THRESH_WIDTH-1:odsh_pkg::THRESH_WIDTH]);
    assign lo_thr  = $signed(thresh[odsh_pkg::THRESH_WIDTH-1:0]);
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Square the sample: high test wins, equal to a threshold holds
    always_comb begin
        gate_next = gate_reg;
        priority if (s_sample > hi_thr) begin
            gate_next = 1'b1;
        end else if (s_sample < lo_thr) begin
            gate_next = 1'b0;
        end else begin
            gate_next = gate_reg;
        end
    end

    // Advance the counter on a falling gate edge, wrapping at full scale
    always_comb begin
        count_next = count_reg;
        if (gate_reg && !gate_next) begin
            count_next = count_reg + odsh_pkg::count_t'(1);
        end
    end

    // Hold state between requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg  <= 1'b0;
            count_reg <= '0;
        end else if (accept) begin
            gate_reg  <= gate_next;
            count_reg <= count_next;
        end
    end

    assign push             = accept;
    assign push_entry.count = count_next;
    assign push_entry.last  = s_last_sample;
    assign f_stat.gate      = gate_reg;
    assign f_stat.count     = count_reg;

endmodule

FILE: design/odsh_queue.sv
// Short request queue between the front end and the mixer.
module odsh_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  odsh_pkg::entry_t      push_entry,
    input  logic                  pop,
    output odsh_pkg::entry_t      head,
    output odsh_pkg::queue_stat_t q_stat
);

    odsh_pkg::entry_t                      mem_reg [odsh_pkg::QUEUE_DEPTH];
    logic [odsh_pkg::QPTR_WIDTH-1:0]       wr_ptr_reg;
    logic [odsh_pkg::QPTR_WIDTH-1:0]       rd_ptr_reg;
    logic [odsh_pkg::QCNT_WIDTH-1:0]       cnt_reg;
    logic [odsh_pkg::QCNT_WIDTH-1:0]       cnt_next;

    // Advance the fill count on push and pop
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + odsh_pkg::QCNT_WIDTH'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - odsh_pkg::QCNT_WIDTH'(1);
        end
    end

    // Pointers wrap at the queue depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == odsh_pkg::QUEUE_DEPTH - 1) ? '0
                            : wr_ptr_reg + odsh_pkg::QPTR_WIDTH'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == odsh_pkg::QUEUE_DEPTH - 1) ? '0
                            : rd_ptr_reg + odsh_pkg::QPTR_WIDTH'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head             = mem_reg[rd_ptr_reg];
    assign q_stat.not_empty = (cnt_reg != '0);
    assign q_stat.full      = (32'(cnt_reg) == odsh_pkg::QUEUE_DEPTH);

endmodule

FILE: design/odsh_back.sv
// Back end: mixes the weighted bipolar divider stages into the output register.
module odsh_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  odsh_pkg::entry_t                       head,
    input  odsh_pkg::queue_stat_t                  q_stat,
    input  odsh_pkg::weight_arr_t                  weights,
    output logic                                   pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [odsh_pkg::MIX_WIDTH-1:0]  m_mix,
    output logic                                   m_last_mix
);

    logic                                  valid_reg;
    logic signed [odsh_pkg::MIX_WIDTH-1:0] mix_reg;
    logic signed [odsh_pkg::MIX_WIDTH-1:0] mix_next;
    logic                                  last_reg;
    logic signed [odsh_pkg::MIX_WIDTH-1:0] term;

    assign pop = q_stat.not_empty && (!valid_reg || m_ready);

    // Add each stage weight when its bit is set, subtract it when clear
    always_comb begin
        mix_next = '0;
        term     = '0;
        for (int k = 0; k < odsh_pkg::STAGES; k++) begin
            if (k < odsh_pkg::NUM_WEIGHTS) begin
                term = {{(odsh_pkg::MIX_WIDTH-odsh_pkg::WEIGHT_WIDTH)
                         {weights[k][odsh_pkg::WEIGHT_WIDTH-1]}}, weights[k]};
            end else begin
                term = '0;
            end
            if (head.count[k]) begin
                mix_next = mix_next + term;
            end else begin
                mix_next = mix_next - term;
            end
        end
    end

    // Output register: load on pop, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            mix_reg  <= mix_next;
            last_reg <= head.last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_mix      = mix_reg;
    assign m_last_mix = last_reg;

endmodule

FILE: design/octave_divider_sub_harmonic_mixer.sv
// An accepted request is queued, then popped into the output register that drives m_valid.
// Throughput: one sample per clock while the queue has room; the front end steps the counter,
// the back end's seven-weight adder chain sets the mixer path, and a two-entry queue parts the two.
// Reset (synchronous, active low): gate and divider counter clear, queue and output
// empty, thresholds and stage weights return to their default values.
module octave_divider_sub_harmonic_mixer (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [odsh_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                   s_last_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [odsh_pkg::MIX_WIDTH-1:0]  m_mix,
    output logic                                   m_last_mix,
    input  logic                                   cfg_wr_en,
    input  logic [odsh_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [odsh_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    odsh_pkg::thresh_t     thresh_reg;
    odsh_pkg::thresh_t     thresh_next;
    odsh_pkg::weight_arr_t weights_reg;
    odsh_pkg::weight_arr_t weights_next;
    logic                  push;
    logic                  pop;
    odsh_pkg::entry_t      push_entry;
    odsh_pkg::entry_t      head;
    odsh_pkg::queue_stat_t q_stat;
    odsh_pkg::front_stat_t f_stat;

    // Decode configuration writes
    always_comb begin
        thresh_next  = thresh_reg;
        weights_next = weights_reg;
        if (cfg_wr_en) begin
            if (cfg_index == odsh_pkg::REG_THRESH) begin
                thresh_next = cfg_data[2*odsh_pkg::THRESH_WIDTH-1:0];
            end
            for (int k = 0; k < odsh_pkg::NUM_WEIGHTS; k++) begin
                if (cfg_index == odsh_pkg::cfg_index_t'(odsh_pkg::REG_WEIGHT_0 + k)) begin
                    weights_next[k] = cfg_data[odsh_pkg::WEIGHT_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= odsh_pkg::THRESH_RESET;
            weights_reg <= odsh_pkg::WEIGHT_RESET;
        end else begin
            thresh_reg  <= thresh_next;
            weights_reg <= weights_next;
        end
    end

    odsh_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .thresh        (thresh_reg),
        .q_stat        (q_stat),
        .push          (push),
        .push_entry    (push_entry),
        .f_stat        (f_stat)
    );

    odsh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    odsh_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_stat     (q_stat),
        .weights    (weights_reg),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_mix      (m_mix),
        .m_last_mix (m_last_mix)
    );

    // The mixer never pops an empty queue
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.not_empty)
        else $error("pop from empty queue");

    // Counter and gate move only on an accepted request
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) |=> $stable(f_stat))
        else $error("front state changed without a request");

    // A request entering an idle pipe passes through the queue and shows up on m_valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !q_stat.not_empty && (!m_valid || m_ready))
        |-> ##2 m_valid)
        else $error("result missing after idle-pipe request");

    // The queue never asks for input while full and the front pushes only when ready
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("push into full queue");

endmodule
